### sv/isg_pkg.sv
// ----------------------------------------------------------------------------
// isg_pkg
// Shared types and constants for the ISAAC random word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package isg_pkg;

    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_INIT  = 3'd1;
    localparam logic [2:0] CMD_NEXT  = 3'd2;
    localparam logic [2:0] CMD_REGEN = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_SEED = 2'd2;
    localparam logic [1:0] MODE_ALT  = 2'd3;

    localparam logic [31:0] GOLDEN = 32'h9E3779B9;

    typedef struct packed {
        logic        golden;
        logic        line;
        logic [2:0]  line_idx;
        logic        add;
        logic [2:0]  add_idx;
        logic [31:0] add_word;
        logic [2:0]  rd_idx;
    } isg_mix_ctrl_t;

endpackage

`default_nettype wire

### sv/isg_in_if.sv
// ----------------------------------------------------------------------------
// isg_in_if
// Command channel: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface isg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  seed_index;
    logic [31:0] seed_word;
    logic [1:0]  seed_mode;

    modport source (output valid, cmd, seed_index, seed_word, seed_mode, input ready);
    modport sink (input valid, cmd, seed_index, seed_word, seed_mode, output ready);
endinterface

`default_nettype wire

### sv/isg_out_if.sv
// ----------------------------------------------------------------------------
// isg_out_if
// Result channel: valid/ready handshake with generated word payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface isg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;
    logic        word_valid;

    modport source (output valid, random_word, word_valid, input ready);
    modport sink (input valid, random_word, word_valid, output ready);
endinterface

`default_nettype wire

### sv/isaac_random_generator.sv
// ----------------------------------------------------------------------------
// isaac_random_generator
// ISAAC-32 generator: memory store and result store in synchronous RAMs.
//
// in_ch takes one command word (load seed, initialise, next, regenerate,
// clear); out_ch returns exactly one result word per command. Only next
// returns a generated word with word_valid set; the others acknowledge with
// a zero word. Commands run one at a time from a sequencer.
// Command steps, SIZE = 2^SIZE_LOG:
//   load seed, unused codes: straight to the response
//   next word: reads the result store, after a regeneration when the block is used up
//   regenerate: states RG0 to RG3 for each of the SIZE memory entries
//   initialise: golden fill, scramble lines, a fill pass that adds the seed
//     words only in seed mode, a second pass adding memory words unless no seed
//     + two regenerations
//   clear: one entry of both stores zeroed per cycle
// A next word also bears its share of the regeneration of its block.
// Reset clears the accumulators and the word count; the RAMs hold
// garbage until initialised. A stalled receiver holds the result register;
// the next command is still taken and waits until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module isaac_random_generator
    import isg_pkg::*;
#(
    parameter int SIZE_LOG = 8
) (
    input wire logic  clk,
    input wire logic  rst_n,
    isg_in_if.sink    in_ch,
    isg_out_if.source out_ch
);

    localparam int SL = SIZE_LOG;
    localparam logic [SL-1:0] HALF      = SL'(1) << (SL - 1);
    localparam logic [SL-1:0] LAST_IDX  = '1;
    localparam logic [SL-1:0] LAST_BASE = SL'((1 << SL) - 8);
    localparam logic [SL:0]   WL_SIZE   = (SL + 1)'(1 << SL);

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_RES  = 2'd1;
    localparam logic [1:0] SRC_MEM  = 2'd2;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CLEAR  = 13'b0000000000010,
        ST_MIX    = 13'b0000000000100,
        ST_FLOAD  = 13'b0000000001000,
        ST_FSCR   = 13'b0000000010000,
        ST_FSTORE = 13'b0000000100000,
        ST_RG0    = 13'b0000001000000,
        ST_RG1    = 13'b0000010000000,
        ST_RG2    = 13'b0000100000000,
        ST_RG3    = 13'b0001000000000,
        ST_NEXT   = 13'b0010000000000,
        ST_NRD    = 13'b0100000000000,
        ST_RESP   = 13'b1000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [SL-1:0] j_reg, j_next;
    logic [SL-1:0] base_reg, base_next;
    logic [4:0]    k_reg, k_next;
    logic [1:0]    mode_reg, mode_next;
    logic [1:0]    src_reg, src_next;
    logic          pass_reg, pass_next;
    logic          again_reg, again_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [31:0]   cnt_reg, cnt_next;
    logic [31:0]   x_reg, x_next;
    logic [31:0]   y_reg, y_next;
    logic          fwd_reg, fwd_next;
    logic [SL:0]   wl_reg, wl_next;
    logic [31:0]   resp_word_reg, resp_word_next;
    logic          resp_flag_reg, resp_flag_next;
    logic [31:0]   out_word_reg, out_word_next;
    logic          out_flag_reg, out_flag_next;
    logic          out_valid_reg, out_valid_next;

    logic          im_we;
    logic [SL-1:0] im_waddr;
    logic [31:0]   im_wdata;
    logic [SL-1:0] im_ra;
    logic [SL-1:0] im_rb;
    logic [31:0]   ia_rd;
    logic [31:0]   ib_rd;
    logic          rm_we;
    logic [SL-1:0] rm_waddr;
    logic [31:0]   rm_wdata;
    logic [SL-1:0] rm_ra;
    logic [31:0]   rm_rd;

    isg_mix_ctrl_t mix;
    logic [31:0]   mix_word;

    logic          accept;
    logic          go_regen;
    logic          go_group;
    logic [31:0]   mixed;
    logic [31:0]   y_val;
    logic [31:0]   b_new;
    logic [31:0]   b_base;
    logic [SL:0]   wl_dec;
    logic [SL-1:0] faddr;
    logic          out_free;

    isg_ram #(.ADDR_W(SL)) u_mem_a (
        .clk(clk), .we(im_we), .waddr(im_waddr), .wdata(im_wdata),
        .raddr(im_ra), .rdata(ia_rd)
    );

    isg_ram #(.ADDR_W(SL)) u_mem_b (
        .clk(clk), .we(im_we), .waddr(im_waddr), .wdata(im_wdata),
        .raddr(im_rb), .rdata(ib_rd)
    );

    isg_ram #(.ADDR_W(SL)) u_res (
        .clk(clk), .we(rm_we), .waddr(rm_waddr), .wdata(rm_wdata),
        .raddr(rm_ra), .rdata(rm_rd)
    );

    isg_mixer u_mixer (
        .clk(clk), .ctrl(mix), .word(mix_word)
    );

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign accept             = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.random_word = out_word_reg;
    assign out_ch.word_valid  = out_flag_reg;
    assign out_free           = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        case (j_reg[1:0])
            2'd0:    mixed = a_reg << 13;
            2'd1:    mixed = a_reg >> 6;
            2'd2:    mixed = a_reg << 2;
            default: mixed = a_reg >> 16;
        endcase
        y_val  = ia_rd + a_reg + b_reg;
        b_new  = (fwd_reg ? y_reg : ia_rd) + x_reg;
        b_base = (state_reg == ST_RG3) ? b_new : b_reg;
        wl_dec = wl_reg - (SL + 1)'(1);
        faddr  = base_reg + SL'(k_reg[2:0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        mode_next      = mode_reg;
        src_next       = src_reg;
        pass_next      = pass_reg;
        again_next     = again_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        fwd_next       = fwd_reg;
        wl_next        = wl_reg;
        resp_word_next = resp_word_reg;
        resp_flag_next = resp_flag_reg;
        out_word_next  = out_word_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        im_we          = 1'b0;
        im_waddr       = j_reg;
        im_wdata       = '0;
        im_ra          = j_reg;
        im_rb          = j_reg + HALF;
        rm_we          = 1'b0;
        rm_waddr       = j_reg;
        rm_wdata       = '0;
        rm_ra          = faddr;
        mix            = '0;
        mix.rd_idx     = k_reg[2:0];
        mix.line_idx   = k_reg[2:0];
        mix.add_idx    = k_reg[2:0] - 3'd1;
        mix.add_word   = (src_reg == SRC_RES) ? rm_rd : ia_rd;
        go_regen       = 1'b0;
        go_group       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = in_ch.cmd;
                    resp_word_next = '0;
                    resp_flag_next = 1'b0;
                    case (in_ch.cmd)
                        CMD_LOAD:
                        begin
                            rm_we      = 1'b1;
                            rm_waddr   = SL'(in_ch.seed_index);
                            rm_wdata   = in_ch.seed_word;
                            state_next = ST_RESP;
                        end
                        CMD_INIT:
                        begin
                            a_next     = '0;
                            b_next     = '0;
                            cnt_next   = '0;
                            wl_next    = '0;
                            mode_next  = (in_ch.seed_mode == MODE_ALT) ? MODE_SEED
                                                                       : in_ch.seed_mode;
                            mix.golden = 1'b1;
                            k_next     = '0;
                            state_next = ST_MIX;
                        end
                        CMD_NEXT:
                        begin
                            if (wl_reg == '0)
                            begin
                                go_regen = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_NEXT;
                            end
                        end
                        CMD_REGEN:
                        begin
                            go_regen = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            a_next     = '0;
                            b_next     = '0;
                            cnt_next   = '0;
                            wl_next    = '0;
                            j_next     = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                im_we  = 1'b1;
                rm_we  = 1'b1;
                j_next = j_reg + SL'(1);
                if (j_reg == LAST_IDX)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MIX:
            begin
                mix.line = 1'b1;
                k_next   = k_reg + 5'd1;
                if (k_reg == 5'd31)
                begin
                    pass_next = 1'b0;
                    src_next  = (mode_reg == MODE_SEED) ? SRC_RES : SRC_NONE;
                    base_next = '0;
                    go_group  = 1'b1;
                end
            end
            ST_FLOAD:
            begin
                im_ra   = faddr;
                mix.add = (k_reg != 5'd0);
                k_next  = k_reg + 5'd1;
                if (k_reg == 5'd8)
                begin
                    k_next     = '0;
                    state_next = ST_FSCR;
                end
            end
            ST_FSCR:
            begin
                mix.line = 1'b1;
                k_next   = k_reg + 5'd1;
                if (k_reg[2:0] == 3'd7)
                begin
                    k_next     = '0;
                    state_next = ST_FSTORE;
                end
            end
            ST_FSTORE:
            begin
                im_we    = 1'b1;
                im_waddr = faddr;
                im_wdata = mix_word;
                k_next   = k_reg + 5'd1;
                if (k_reg[2:0] == 3'd7)
                begin
                    if (base_reg != LAST_BASE)
                    begin
                        base_next = base_reg + SL'(8);
                        go_group  = 1'b1;
                    end
                    else if (mode_reg != MODE_NONE && !pass_reg)
                    begin
                        pass_next = 1'b1;
                        src_next  = SRC_MEM;
                        base_next = '0;
                        go_group  = 1'b1;
                    end
                    else
                    begin
                        again_next = 1'b1;
                        go_regen   = 1'b1;
                    end
                end
            end
            ST_RG0:
            begin
                state_next = ST_RG1;
            end
            ST_RG1:
            begin
                x_next     = ia_rd;
                a_next     = (a_reg ^ mixed) + ib_rd;
                im_ra      = ia_rd[2 +: SL];
                state_next = ST_RG2;
            end
            ST_RG2:
            begin
                im_we      = 1'b1;
                im_wdata   = y_val;
                y_next     = y_val;
                im_ra      = y_val[SL + 2 +: SL];
                fwd_next   = (y_val[SL + 2 +: SL] == j_reg);
                state_next = ST_RG3;
            end
            ST_RG3:
            begin
                rm_we    = 1'b1;
                rm_wdata = b_new;
                b_next   = b_new;
                j_next   = j_reg + SL'(1);
                if (j_reg != LAST_IDX)
                begin
                    state_next = ST_RG0;
                end
                else
                begin
                    wl_next = WL_SIZE;
                    if (again_reg)
                    begin
                        again_next = 1'b0;
                        go_regen   = 1'b1;
                    end
                    else if (cmd_reg == CMD_NEXT)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_NEXT:
            begin
                wl_next    = wl_dec;
                rm_ra      = wl_dec[SL-1:0];
                state_next = ST_NRD;
            end
            ST_NRD:
            begin
                resp_word_next = rm_rd;
                resp_flag_next = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_word_next  = resp_word_reg;
                    out_flag_next  = resp_flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (go_group)
        begin
            k_next     = '0;
            state_next = (src_next == SRC_NONE) ? ST_FSCR : ST_FLOAD;
        end

        if (go_regen)
        begin
            cnt_next   = cnt_reg + 32'd1;
            b_next     = b_base + cnt_reg + 32'd1;
            j_next     = '0;
            state_next = ST_RG0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            cnt_reg       <= '0;
            wl_reg        <= '0;
            out_valid_reg <= 1'b0;
            again_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            cnt_reg       <= cnt_next;
            wl_reg        <= wl_next;
            out_valid_reg <= out_valid_next;
            again_reg     <= again_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        base_reg      <= base_next;
        k_reg         <= k_next;
        mode_reg      <= mode_next;
        src_reg       <= src_next;
        pass_reg      <= pass_next;
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        fwd_reg       <= fwd_next;
        resp_word_reg <= resp_word_next;
        resp_flag_reg <= resp_flag_next;
        out_word_reg  <= out_word_next;
        out_flag_reg  <= out_flag_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        wl_reg <= WL_SIZE)
        else $error("word count beyond store size");

    a_resp_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && out_free) |=> out_valid_reg)
        else $error("finished command lost its result");

    a_rg_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RG3 |-> $past(state_reg) == ST_RG2)
        else $error("regeneration step out of order");

endmodule

`default_nettype wire

### sv/isg_ram.sv
// ----------------------------------------------------------------------------
// isg_ram
// Synchronous single-write single-read memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module isg_ram #(
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output      logic [31:0]       rdata
);

    logic [31:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/isg_mixer.sv
// ----------------------------------------------------------------------------
// isg_mixer
// Eight-word mixing register file: one scramble line or one add per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module isg_mixer
    import isg_pkg::*;
(
    input  wire logic          clk,
    input  wire isg_mix_ctrl_t ctrl,
    output      logic [31:0]   word
);

    logic [31:0] v_reg  [8];
    logic [31:0] v_next [8];
    logic [2:0]  i1;
    logic [2:0]  i2;
    logic [2:0]  i3;
    logic [31:0] shifted;
    logic [31:0] t0;

    always_comb
    begin
        i1 = ctrl.line_idx + 3'd1;
        i2 = ctrl.line_idx + 3'd2;
        i3 = ctrl.line_idx + 3'd3;
        case (ctrl.line_idx)
            3'd0:    shifted = v_reg[i1] << 11;
            3'd1:    shifted = v_reg[i1] >> 2;
            3'd2:    shifted = v_reg[i1] << 8;
            3'd3:    shifted = v_reg[i1] >> 16;
            3'd4:    shifted = v_reg[i1] << 10;
            3'd5:    shifted = v_reg[i1] >> 4;
            3'd6:    shifted = v_reg[i1] << 8;
            default: shifted = v_reg[i1] >> 9;
        endcase
        t0 = v_reg[ctrl.line_idx] ^ shifted;
        v_next = v_reg;
        if (ctrl.golden)
        begin
            for (int k = 0; k < 8; k++)
            begin
                v_next[k] = GOLDEN;
            end
        end
        else if (ctrl.line)
        begin
            v_next[ctrl.line_idx] = t0;
            v_next[i3] = v_reg[i3] + t0;
            v_next[i1] = v_reg[i1] + v_reg[i2];
        end
        else if (ctrl.add)
        begin
            v_next[ctrl.add_idx] = v_reg[ctrl.add_idx] + ctrl.add_word;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign word = v_reg[ctrl.rd_idx];

endmodule

`default_nettype wire
